// ===== hdl/uhprh_pkg.sv =====
// ----------------------------------------------------------------------------
// uhprh_pkg
// Types and constants shared by the hub port request handler modules.
// ----------------------------------------------------------------------------
package uhprh_pkg;

  localparam int NUM_PORTS  = 6;
  localparam int PORT_W     = 3;

  localparam int IN_DATA_W  = 72;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 2;

  typedef enum logic [1:0] {
    CMD_CTRL       = 2'd0,
    CMD_CONNECT    = 2'd1,
    CMD_DISCONNECT = 2'd2,
    CMD_NONE       = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    OUT_ACK     = 2'd0,
    OUT_DATA    = 2'd1,
    OUT_IGNORED = 2'd2,
    OUT_FATAL   = 2'd3
  } outcome_t;

  typedef enum logic [3:0] {
    OP_IGNORE,
    OP_FATAL,
    OP_ACK,
    OP_HUB_STATUS,
    OP_PORT_STATUS,
    OP_POWER,
    OP_RESET,
    OP_CLR_CONN,
    OP_CLR_RESET,
    OP_CONNECT,
    OP_DISCONNECT
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctl_cmd_t;

  localparam logic [15:0] ST_EMPTY         = 16'h0100;
  localparam logic [15:0] ST_FULL          = 16'h0103;
  localparam logic [15:0] CH_CONN          = 16'h0001;
  localparam logic [15:0] CH_RESET         = 16'h0010;

  localparam logic [2:0]  CTX_HUB          = 3'd0;
  localparam logic [2:0]  CTX_DEVICE       = 3'd5;

  localparam logic [7:0]  RT_HUB_STATUS    = 8'hA0;
  localparam logic [7:0]  RT_PORT_STATUS   = 8'hA3;
  localparam logic [7:0]  RT_PORT_FEATURE  = 8'h23;

  localparam logic [7:0]  RQ_GET_STATUS    = 8'h00;
  localparam logic [7:0]  RQ_CLEAR_FEATURE = 8'h01;
  localparam logic [7:0]  RQ_SET_FEATURE   = 8'h03;
  localparam logic [7:0]  RQ_SET_INTERFACE = 8'h0B;

  localparam logic [15:0] FEAT_POWER       = 16'h0008;
  localparam logic [15:0] FEAT_RESET       = 16'h0004;
  localparam logic [15:0] FEAT_C_CONN      = 16'h0010;
  localparam logic [15:0] FEAT_C_RESET     = 16'h0014;

  localparam logic [15:0] STATUS_LEN       = 16'd4;

endpackage

// ===== hdl/uhprh_ctrl.sv =====
// ----------------------------------------------------------------------------
// uhprh_ctrl
// Control FSM: load a request, execute it, present the result.
// ----------------------------------------------------------------------------
module uhprh_ctrl
  import uhprh_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output ctl_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_tvalid = 1'b1;
        in_tready  = out_tready;
        if (out_tready) begin
          if (in_tvalid) begin
            cmd.load  = 1'b1;
            state_nxt = S_EXEC;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== hdl/uhprh_datapath.sv =====
// ----------------------------------------------------------------------------
// uhprh_datapath
// Request decode, per-port status and change state, result register.
// ----------------------------------------------------------------------------
module uhprh_datapath
  import uhprh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctl_cmd_t              cmd,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser
);

  // input fields
  logic [2:0]  ctx;
  logic [7:0]  rtype;
  logic [7:0]  rcode;
  logic [15:0] wval;
  logic [15:0] widx;
  logic [15:0] wlen;
  logic [2:0]  eport;
  command_t    command;
  logic        req_port_ok;
  logic        evt_port_ok;

  assign command = command_t'(in_tuser);
  assign ctx     = in_tdata[2:0];
  assign rtype   = in_tdata[10:3];
  assign rcode   = in_tdata[18:11];
  assign wval    = in_tdata[34:19];
  assign widx    = in_tdata[50:35];
  assign wlen    = in_tdata[66:51];
  assign eport   = in_tdata[69:67];

  assign req_port_ok = (widx[7:0] != 8'd0) && (widx[7:0] <= 8'(NUM_PORTS));
  assign evt_port_ok = (eport != 3'd0) && (eport <= 3'(NUM_PORTS));

  op_t              op_r, op_nxt;
  logic [PORT_W-1:0] port_r, port_nxt;

  always_comb begin
    op_nxt   = OP_FATAL;
    port_nxt = widx[PORT_W-1:0];
    if (command == CMD_CONNECT || command == CMD_DISCONNECT) begin
      port_nxt = eport;
      if (!evt_port_ok) begin
        op_nxt = OP_IGNORE;
      end else if (command == CMD_CONNECT) begin
        op_nxt = OP_CONNECT;
      end else begin
        op_nxt = OP_DISCONNECT;
      end
    end else if (command == CMD_NONE) begin
      op_nxt = OP_IGNORE;
    end else if (ctx == CTX_DEVICE && rcode == RQ_SET_INTERFACE) begin
      op_nxt = OP_ACK;
    end else if (ctx == CTX_HUB && rtype == RT_HUB_STATUS && rcode == RQ_GET_STATUS &&
                 wval == 16'd0 && widx == 16'd0 && wlen == STATUS_LEN) begin
      op_nxt = OP_HUB_STATUS;
    end else if (ctx == CTX_HUB && rtype == RT_PORT_STATUS && rcode == RQ_GET_STATUS &&
                 wval == 16'd0 && wlen == STATUS_LEN) begin
      op_nxt = req_port_ok ? OP_PORT_STATUS : OP_IGNORE;
    end else if (ctx == CTX_HUB && rtype == RT_PORT_FEATURE && rcode == RQ_SET_FEATURE &&
                 wlen == 16'd0) begin
      if (!req_port_ok) begin
        op_nxt = OP_IGNORE;
      end else if (wval == FEAT_POWER) begin
        op_nxt = OP_POWER;
      end else if (wval == FEAT_RESET) begin
        op_nxt = OP_RESET;
      end else begin
        op_nxt = OP_ACK;
      end
    end else if (ctx == CTX_HUB && rtype == RT_PORT_FEATURE && rcode == RQ_CLEAR_FEATURE &&
                 wlen == 16'd0) begin
      if (!req_port_ok) begin
        op_nxt = OP_IGNORE;
      end else if (wval == FEAT_C_CONN) begin
        op_nxt = OP_CLR_CONN;
      end else if (wval == FEAT_C_RESET) begin
        op_nxt = OP_CLR_RESET;
      end else begin
        op_nxt = OP_ACK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_nxt;
      port_r <= port_nxt;
    end
  end

  // per-port state: connected flag, connection change, reset change
  logic [NUM_PORTS-1:0] conn_r, conn_nxt;
  logic [NUM_PORTS-1:0] chg_conn_r, chg_conn_nxt;
  logic [NUM_PORTS-1:0] chg_rst_r, chg_rst_nxt;
  logic [7:0]           pend_r, pend_nxt;
  logic [PORT_W-1:0]    cclr_r, cclr_nxt;
  logic [PORT_W-1:0]    rclr_r, rclr_nxt;

  outcome_t    outcome_r, outcome_nxt;
  logic [15:0] sw_r, sw_nxt;
  logic [15:0] cw_r, cw_nxt;
  logic        pdone_r, pdone_nxt;

  logic [PORT_W-1:0] idx;
  assign idx = port_r - PORT_W'(1);

  always_comb begin
    conn_nxt     = conn_r;
    chg_conn_nxt = chg_conn_r;
    chg_rst_nxt  = chg_rst_r;
    pend_nxt     = pend_r;
    cclr_nxt     = cclr_r;
    rclr_nxt     = rclr_r;
    outcome_nxt  = OUT_ACK;
    sw_nxt       = 16'd0;
    cw_nxt       = 16'd0;
    pdone_nxt    = 1'b0;
    case (op_r)
      OP_IGNORE:     outcome_nxt = OUT_IGNORED;
      OP_FATAL:      outcome_nxt = OUT_FATAL;
      OP_HUB_STATUS: outcome_nxt = OUT_DATA;
      OP_PORT_STATUS: begin
        outcome_nxt = OUT_DATA;
        sw_nxt      = conn_r[idx] ? ST_FULL : ST_EMPTY;
        cw_nxt      = (chg_conn_r[idx] ? CH_CONN : 16'd0) |
                      (chg_rst_r[idx] ? CH_RESET : 16'd0);
      end
      OP_POWER: pdone_nxt = (port_r == PORT_W'(NUM_PORTS));
      OP_RESET: begin
        pend_nxt         = 8'd1 << port_r;
        chg_rst_nxt[idx] = 1'b1;
      end
      OP_CLR_CONN: begin
        cclr_nxt          = port_r;
        chg_conn_nxt[idx] = 1'b0;
      end
      OP_CLR_RESET: begin
        rclr_nxt         = port_r;
        chg_rst_nxt[idx] = 1'b0;
      end
      OP_CONNECT, OP_DISCONNECT: begin
        conn_nxt[idx]     = (op_r == OP_CONNECT);
        chg_conn_nxt[idx] = 1'b1;
        chg_rst_nxt[idx]  = 1'b0;
        pend_nxt          = 8'd1 << port_r;
        if (op_r == OP_CONNECT) begin
          rclr_nxt = '0;
        end else begin
          cclr_nxt = '0;
        end
      end
      default: outcome_nxt = OUT_ACK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conn_r     <= '0;
      chg_conn_r <= '0;
      chg_rst_r  <= '0;
      pend_r     <= '0;
      cclr_r     <= '0;
      rclr_r     <= '0;
    end else if (cmd.exec) begin
      conn_r     <= conn_nxt;
      chg_conn_r <= chg_conn_nxt;
      chg_rst_r  <= chg_rst_nxt;
      pend_r     <= pend_nxt;
      cclr_r     <= cclr_nxt;
      rclr_r     <= rclr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      outcome_r <= outcome_nxt;
      sw_r      <= sw_nxt;
      cw_r      <= cw_nxt;
      pdone_r   <= pdone_nxt;
    end
  end

  assign out_tuser = outcome_r;
  assign out_tdata = {1'b0, rclr_r, cclr_r, pdone_r, pend_r, cw_r, sw_r};

  // at most one port flagged, never the hub bit
  assert property (@(posedge clk) disable iff (!rst_n) $onehot0(pend_r))
    else $error("interrupt bitmap has more than one bit set");
  assert property (@(posedge clk) disable iff (!rst_n) !pend_r[0])
    else $error("interrupt bitmap flags the hub itself");
  assert property (@(posedge clk) disable iff (!rst_n)
                   cclr_r <= PORT_W'(NUM_PORTS) && rclr_r <= PORT_W'(NUM_PORTS))
    else $error("last cleared port out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
                   cmd.exec && op_r == OP_PORT_STATUS |=> outcome_r == OUT_DATA &&
                   (sw_r == ST_EMPTY || sw_r == ST_FULL))
    else $error("port status transfer carries a bad status word");

endmodule

// ===== hdl/usb_hub_port_request_handler.sv =====
// Timing: out_tvalid rises once the request has passed through the execute state
// (S_EXEC) that follows the input transfer.
// The control FSM executes one request at a time: while a result waits, a new
// request is accepted only together with the result transfer.
// Reset: synchronous, active low; all ports disconnected,
// change bits, interrupt bitmap and last-cleared ports zeroed.
// ----------------------------------------------------------------------------
// usb_hub_port_request_handler
// Port side of a downstream hub: status, feature and connect event handling.
// ----------------------------------------------------------------------------
module usb_hub_port_request_handler
  import uhprh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // device_context, request_type, request_code, feature_value,
  // request_index, request_length, event_port
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // command
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // status_word, change_word, interrupt_bits, power_done,
  // last_connection_clear, last_reset_clear
  output logic [OUT_DATA_W-1:0] out_tdata,
  // outcome
  output logic [OUT_USER_W-1:0] out_tuser
);

  ctl_cmd_t cmd;

  uhprh_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  uhprh_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

// ===== dv/usb_hub_port_request_handler_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_hub_port_request_handler_test
// Self-checking bench for the hub port request handler. A queue of control
// requests and connect/disconnect events, directed then random, is driven
// with random gaps. A tracking copy of the port status/change words, the
// interrupt bitmap and the last-cleared ports predicts every reply, which is
// checked field by field against the result stream under random back-pressure.
// ----------------------------------------------------------------------------
module usb_hub_port_request_handler_test;
  import uhprh_pkg::*;

  localparam int RANDOM_ITEMS   = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int HOLD_AT_REPLY  = 500;
  localparam int DRAIN_AT_ITEM  = 1000;
  localparam int STALL_LIMIT    = 4000;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic        drain;
    command_t    cmd;
    logic [2:0]  ctx;
    logic [7:0]  rtype;
    logic [7:0]  rcode;
    logic [15:0] wval;
    logic [15:0] widx;
    logic [15:0] wlen;
    logic [2:0]  eport;
  } hub_item_t;

  typedef struct packed {
    outcome_t    outcome;
    logic [15:0] status_word;
    logic [15:0] change_word;
    logic [7:0]  irq;
    logic        pwr_done;
    logic [2:0]  conn_clr;
    logic [2:0]  rst_clr;
  } hub_reply_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  usb_hub_port_request_handler uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  // tracked hub state
  logic [15:0] port_stat [1:NUM_PORTS];
  logic [15:0] port_chg  [1:NUM_PORTS];
  logic [7:0]  irq_bits;
  logic [2:0]  conn_clr_port;
  logic [2:0]  rst_clr_port;

  hub_item_t  pending_items[$];
  hub_reply_t expected_replies[$];

  int  items_queued   = 0;
  int  requests_taken = 0;
  int  replies_seen   = 0;
  int  errors         = 0;
  int  stall_cycles   = 0;
  int  tx_gap         = 0;
  int  rx_wait        = 0;
  int  hold_left      = 0;
  bit  hold_done      = 1'b0;
  bit  rush           = 1'b0;
  bit  in_xfer        = 1'b0;
  bit  out_xfer       = 1'b0;
  int  outcome_tally [4];

  function automatic bit port_valid(int p);
    return p >= 1 && p <= NUM_PORTS;
  endfunction

  function automatic hub_reply_t hub_apply_request(hub_item_t it);
    hub_reply_t r;
    int         p;
    r         = '0;
    r.outcome = OUT_FATAL;
    p         = int'(it.widx[7:0]);
    if (it.cmd == CMD_CONNECT || it.cmd == CMD_DISCONNECT) begin
      if (port_valid(int'(it.eport))) begin
        if (it.cmd == CMD_CONNECT) begin
          rst_clr_port        = '0;
          port_stat[it.eport] = ST_FULL;
        end else begin
          conn_clr_port       = '0;
          port_stat[it.eport] = ST_EMPTY;
        end
        irq_bits           = 8'(1 << it.eport);
        port_chg[it.eport] = CH_CONN;
        r.outcome          = OUT_ACK;
      end else begin
        r.outcome = OUT_IGNORED;
      end
    end else if (it.cmd == CMD_NONE) begin
      r.outcome = OUT_IGNORED;
    end else if (it.ctx == CTX_DEVICE && it.rcode == RQ_SET_INTERFACE) begin
      r.outcome = OUT_ACK;
    end else if (it.ctx == CTX_HUB && it.rtype == RT_HUB_STATUS &&
                 it.rcode == RQ_GET_STATUS && it.wval == '0 && it.widx == '0 &&
                 it.wlen == STATUS_LEN) begin
      r.outcome = OUT_DATA;
    end else if (it.ctx == CTX_HUB && it.rtype == RT_PORT_STATUS &&
                 it.rcode == RQ_GET_STATUS && it.wval == '0 &&
                 it.wlen == STATUS_LEN) begin
      if (port_valid(p)) begin
        r.status_word = port_stat[p];
        r.change_word = port_chg[p];
        r.outcome     = OUT_DATA;
      end else begin
        r.outcome = OUT_IGNORED;
      end
    end else if (it.ctx == CTX_HUB && it.rtype == RT_PORT_FEATURE &&
                 it.rcode == RQ_SET_FEATURE && it.wlen == '0) begin
      if (port_valid(p)) begin
        r.outcome = OUT_ACK;
        if (it.wval == FEAT_POWER) begin
          r.pwr_done = (p == NUM_PORTS);
        end else if (it.wval == FEAT_RESET) begin
          irq_bits    = 8'(1 << p);
          port_chg[p] = port_chg[p] | CH_RESET;
        end
      end else begin
        r.outcome = OUT_IGNORED;
      end
    end else if (it.ctx == CTX_HUB && it.rtype == RT_PORT_FEATURE &&
                 it.rcode == RQ_CLEAR_FEATURE && it.wlen == '0) begin
      if (port_valid(p)) begin
        r.outcome = OUT_ACK;
        if (it.wval == FEAT_C_CONN) begin
          conn_clr_port = 3'(p);
          port_chg[p]   = port_chg[p] & ~CH_CONN;
        end else if (it.wval == FEAT_C_RESET) begin
          rst_clr_port = 3'(p);
          port_chg[p]  = port_chg[p] & ~CH_RESET;
        end
      end else begin
        r.outcome = OUT_IGNORED;
      end
    end
    r.irq      = irq_bits;
    r.conn_clr = conn_clr_port;
    r.rst_clr  = rst_clr_port;
    return r;
  endfunction

  function automatic int draw_gap();
    return rush ? 0 : $urandom_range(0, 15);
  endfunction

  // mostly a valid port, sometimes 0, one past the end or any byte
  function automatic logic [7:0] pick_port();
    case ($urandom_range(0, 19))
      0:       return 8'd0;
      1:       return 8'(NUM_PORTS + 1);
      2:       return 8'($urandom);
      default: return 8'($urandom_range(1, NUM_PORTS));
    endcase
  endfunction

  function automatic logic [15:0] pick_feature(logic [15:0] a, logic [15:0] b);
    case ($urandom_range(0, 9))
      0:       return 16'($urandom);
      1, 2, 3: return b;
      default: return a;
    endcase
  endfunction

  task automatic queue_item(command_t cmd, logic [2:0] ctx, logic [7:0] rtype,
                            logic [7:0] rcode, logic [15:0] wval, logic [15:0] widx,
                            logic [15:0] wlen, logic [2:0] eport);
    hub_item_t it;
    it = '{1'b0, cmd, ctx, rtype, rcode, wval, widx, wlen, eport};
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic queue_random_item(bit drain);
    hub_item_t it;
    int        pick;
    it.drain = drain;
    it.cmd   = CMD_CTRL;
    it.ctx   = CTX_HUB;
    it.rtype = 8'($urandom);
    it.rcode = 8'($urandom);
    it.wval  = 16'($urandom);
    it.widx  = 16'($urandom);
    it.wlen  = 16'($urandom);
    it.eport = 3'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      it.cmd   = $urandom_range(0, 1) ? CMD_CONNECT : CMD_DISCONNECT;
      it.eport = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 1) * 7)
                                             : 3'($urandom_range(1, NUM_PORTS));
    end else if (pick < 90) begin
      case ($urandom_range(0, 5))
        0: begin
          it.rtype = RT_HUB_STATUS;
          it.rcode = RQ_GET_STATUS;
          it.wval  = '0;
          it.widx  = '0;
          it.wlen  = STATUS_LEN;
        end
        1, 2: begin
          it.rtype = RT_PORT_STATUS;
          it.rcode = RQ_GET_STATUS;
          it.wval  = '0;
          it.widx  = {8'($urandom), pick_port()};
          it.wlen  = STATUS_LEN;
        end
        3: begin
          it.rtype = RT_PORT_FEATURE;
          it.rcode = RQ_SET_FEATURE;
          it.wval  = pick_feature(FEAT_RESET, FEAT_POWER);
          it.widx  = {8'($urandom), pick_port()};
          it.wlen  = '0;
        end
        4: begin
          it.rtype = RT_PORT_FEATURE;
          it.rcode = RQ_CLEAR_FEATURE;
          it.wval  = pick_feature(FEAT_C_CONN, FEAT_C_RESET);
          it.widx  = {8'($urandom), pick_port()};
          it.wlen  = '0;
        end
        default: begin
          it.ctx   = CTX_DEVICE;
          it.rcode = RQ_SET_INTERFACE;
        end
      endcase
      // near misses: one bit off in a decoded field
      if (pick >= 80) begin
        case ($urandom_range(0, 4))
          0:       it.ctx   ^= 3'(1 << $urandom_range(0, 2));
          1:       it.rtype ^= 8'(1 << $urandom_range(0, 7));
          2:       it.rcode ^= 8'(1 << $urandom_range(0, 7));
          3:       it.wval  ^= 16'(1 << $urandom_range(0, 15));
          default: it.wlen  ^= 16'(1 << $urandom_range(0, 15));
        endcase
      end
    end else begin
      it.cmd = command_t'($urandom_range(0, 3));
      it.ctx = 3'($urandom);
    end
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic note_failure(string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  task automatic check_reply(hub_reply_t got);
    hub_reply_t exp;
    string      bad;
    if (expected_replies.size() == 0) begin
      note_failure($sformatf("unexpected reply outcome=%0d data=%h",
                             got.outcome, out_tdata));
      return;
    end
    exp = expected_replies.pop_front();
    bad = "";
    if (got.outcome     !== exp.outcome)     bad = {bad, " outcome"};
    if (got.status_word !== exp.status_word) bad = {bad, " status_word"};
    if (got.change_word !== exp.change_word) bad = {bad, " change_word"};
    if (got.irq         !== exp.irq)         bad = {bad, " interrupt_bits"};
    if (got.pwr_done    !== exp.pwr_done)    bad = {bad, " power_done"};
    if (got.conn_clr    !== exp.conn_clr)    bad = {bad, " last_connection_clear"};
    if (got.rst_clr     !== exp.rst_clr)     bad = {bad, " last_reset_clear"};
    if (bad != "") begin
      note_failure($sformatf(
        "reply %0d mismatch (%s): exp o=%0d sw=%h cw=%h irq=%h pd=%0d lc=%0d lr=%0d, got o=%0d sw=%h cw=%h irq=%h pd=%0d lc=%0d lr=%0d",
        replies_seen, bad, exp.outcome, exp.status_word, exp.change_word, exp.irq,
        exp.pwr_done, exp.conn_clr, exp.rst_clr, got.outcome, got.status_word,
        got.change_word, got.irq, got.pwr_done, got.conn_clr, got.rst_clr));
    end
  endtask

  // input side: record accepted transfers and predict their replies
  always @(posedge clk) begin
    hub_item_t  it;
    hub_reply_t r;
    in_xfer <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      it       = '0;
      it.cmd   = command_t'(in_tuser);
      it.ctx   = in_tdata[2:0];
      it.rtype = in_tdata[10:3];
      it.rcode = in_tdata[18:11];
      it.wval  = in_tdata[34:19];
      it.widx  = in_tdata[50:35];
      it.wlen  = in_tdata[66:51];
      it.eport = in_tdata[69:67];
      r = hub_apply_request(it);
      expected_replies.push_back(r);
      outcome_tally[r.outcome]++;
      requests_taken++;
      if (requests_taken % 64 == 0) rush = ($urandom_range(0, 3) == 0);
    end
  end

  // result side: check each transfer against the oldest prediction
  always @(posedge clk) begin
    hub_reply_t got;
    out_xfer <= rst_n && out_tvalid && out_tready;
    if (rst_n && out_tvalid && out_tready) begin
      got.outcome     = outcome_t'(out_tuser);
      got.status_word = out_tdata[15:0];
      got.change_word = out_tdata[31:16];
      got.irq         = out_tdata[39:32];
      got.pwr_done    = out_tdata[40];
      got.conn_clr    = out_tdata[43:41];
      got.rst_clr     = out_tdata[46:44];
      check_reply(got);
      replies_seen++;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d replies outstanding",
               stall_cycles, expected_replies.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // sender
  always @(negedge clk) begin
    hub_item_t it;
    logic      next_valid;
    if (rst_n) begin
      if (in_xfer) tx_gap = draw_gap();
      next_valid = in_tvalid && !in_xfer;
      if (!next_valid) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_items.size() > 0 &&
                     (!pending_items[0].drain || expected_replies.size() == 0)) begin
          it         = pending_items.pop_front();
          in_tdata   <= {2'b00, it.eport, it.wlen, it.widx, it.wval,
                         it.rcode, it.rtype, it.ctx};
          in_tuser   <= it.cmd;
          next_valid = 1'b1;
        end
      end
      in_tvalid <= next_valid;
    end
  end

  // receiver, with one long hold-off to back the block up
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_xfer) rx_wait = draw_gap();
      if (!hold_done && replies_seen >= HOLD_AT_REPLY) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    for (int i = 1; i <= NUM_PORTS; i++) begin
      port_stat[i] = ST_EMPTY;
      port_chg[i]  = '0;
    end
    irq_bits      = '0;
    conn_clr_port = '0;
    rst_clr_port  = '0;
    for (int i = 0; i < 4; i++) outcome_tally[i] = 0;

    // directed: status reads, events, features, set interface, junk
    queue_item(CMD_CTRL, CTX_HUB, RT_HUB_STATUS, RQ_GET_STATUS, 16'h0, 16'h0, STATUS_LEN, 3'd0);
    queue_item(CMD_CTRL, CTX_HUB, RT_PORT_STATUS, RQ_GET_STATUS, 16'h0, 16'h0001, STATUS_LEN, 3'd7);
    queue_item(CMD_CTRL, CTX_HUB, RT_PORT_STATUS, RQ_GET_STATUS, 16'h0, 16'hFF00, STATUS_LEN, 3'd0);
    queue_item(CMD_CTRL, CTX_HUB, RT_PORT_STATUS, RQ_GET_STATUS, 16'h0, 16'h00FF, STATUS_LEN, 3'd0);
    queue_item(CMD_CONNECT, 3'd7, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd1);
    queue_item(CMD_CONNECT, CTX_HUB, 8'h00, 8'h00, 16'h0, 16'h0, 16'h0, 3'(NUM_PORTS));
    queue_item(CMD_CONNECT, CTX_HUB, 8'h00, 8'h00, 16'h0, 16'h0, 16'h0, 3'd0);
    queue_item(CMD_DISCONNECT, CTX_HUB, 8'h00, 8'h00, 16'h0, 16'h0, 16'h0, 3'd7);
    queue_item(CMD_DISCONNECT, CTX_HUB, 8'h00, 8'h00, 16'h0, 16'h0, 16'h0, 3'd3);
    queue_item(CMD_CTRL, CTX_HUB, RT_PORT_FEATURE, RQ_SET_FEATURE, FEAT_POWER, 16'(NUM_PORTS), 16'h0, 3'd0);
    queue_item(CMD_CTRL, CTX_HUB, RT_PORT_FEATURE, RQ_SET_FEATURE, FEAT_POWER, 16'hAB01, 16'h0, 3'd0);
    queue_item(CMD_CTRL, CTX_HUB, RT_PORT_FEATURE, RQ_SET_FEATURE, FEAT_RESET, 16'h0002, 16'h0, 3'd0);
    queue_item(CMD_CTRL, CTX_HUB, RT_PORT_FEATURE, RQ_SET_FEATURE, 16'hFFFF, 16'h0003, 16'h0, 3'd0);
    queue_item(CMD_CTRL, CTX_HUB, RT_PORT_FEATURE, RQ_SET_FEATURE, FEAT_RESET, 16'(NUM_PORTS + 1), 16'h0, 3'd0);
    queue_item(CMD_CTRL, CTX_HUB, RT_PORT_FEATURE, RQ_CLEAR_FEATURE, FEAT_C_CONN, 16'h0001, 16'h0, 3'd0);
    queue_item(CMD_CTRL, CTX_HUB, RT_PORT_FEATURE, RQ_CLEAR_FEATURE, FEAT_C_RESET, 16'h0002, 16'h0, 3'd0);
    queue_item(CMD_CTRL, CTX_HUB, RT_PORT_FEATURE, RQ_CLEAR_FEATURE, 16'h0000, 16'h0004, 16'h0, 3'd0);
    queue_item(CMD_CTRL, CTX_HUB, RT_PORT_FEATURE, RQ_CLEAR_FEATURE, FEAT_C_CONN, 16'h0000, 16'h0, 3'd0);
    queue_item(CMD_CTRL, CTX_DEVICE, 8'hFF, RQ_SET_INTERFACE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7);
    queue_item(CMD_CTRL, CTX_HUB, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7);
    queue_item(CMD_CTRL, CTX_HUB, RT_HUB_STATUS, RQ_GET_STATUS, 16'h0, 16'h0, 16'h0005, 3'd0);
    queue_item(CMD_NONE, CTX_HUB, RT_HUB_STATUS, RQ_GET_STATUS, 16'h0, 16'h0, STATUS_LEN, 3'd1);
    queue_item(CMD_CTRL, CTX_HUB, RT_PORT_STATUS, RQ_GET_STATUS, 16'h0, 16'h0002, STATUS_LEN, 3'd0);
    queue_item(CMD_CTRL, CTX_HUB, RT_PORT_STATUS, RQ_GET_STATUS, 16'h0, 16'(NUM_PORTS), STATUS_LEN, 3'd0);

    for (int i = 0; i < RANDOM_ITEMS; i++) queue_random_item(i == 0 || i == DRAIN_AT_ITEM);

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    while (requests_taken < items_queued || expected_replies.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);

    if (expected_replies.size() != 0)
      note_failure($sformatf("%0d replies never arrived", expected_replies.size()));
    $display("Sent %0d requests and events; %0d replies checked, %0d failures.",
             requests_taken, replies_seen, errors);
    $display("Outcomes: ack %0d, data %0d, ignored %0d, fatal %0d.",
             outcome_tally[OUT_ACK], outcome_tally[OUT_DATA],
             outcome_tally[OUT_IGNORED], outcome_tally[OUT_FATAL]);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
